@@ hdl/spc_pkg.sv @@
`timescale 1ns / 1ps

package spc_pkg;

  localparam int LEGS_DEF  = 6;
  localparam int GRIP_DEF  = 2;
  localparam int NTRIM     = 12;
  localparam int ANGLE_MAX = 180;

  // hip collision window
  localparam logic [7:0] CLAMP_LO = 8'd85;
  localparam logic [7:0] CLAMP_HI = 8'd100;

  localparam logic        TRIM_EN_RST   = 1'b1;
  localparam logic [11:0] PULSE_MIN_RST = 12'd150;
  localparam logic [11:0] PULSE_MAX_RST = 12'd600;
  localparam logic [7:0]  TRIM_MID_RST  = 8'd127;

  // x/180 == (x>>2)/45 == ((x>>2) * RECIP_M) >> RECIP_SHIFT for x < 2^20
  localparam logic [18:0] RECIP_M     = 19'd372828;
  localparam int          RECIP_SHIFT = 24;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_COMMIT = 2'd2,
    OP_TRIM   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_TRIM_EN   = 2'd0,
    CFG_PULSE_MIN = 2'd1,
    CFG_PULSE_MAX = 2'd2,
    CFG_TRIM_MID  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic        trim_enable;
    logic [11:0] pulse_min;
    logic [11:0] pulse_max;
    logic [7:0]  trim_mid;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic [7:0] angle;
    logic [7:0] trim;
    logic       use_trim;
  } pulse_req_t;

  typedef struct packed {
    logic        done;
    logic [11:0] value;
  } pulse_rsp_t;

endpackage

@@ hdl/servo_pulse_commit_with_collision_clamp.sv @@
`timescale 1ns / 1ps
// A set angle outside a transaction gives its pulse through the pulse unit and the output register.
// Commit first runs the hip clamp over each hip pair, then gives one pulse per servo in turn, held
// while the output stalls; begin, trim write and deferred set stay in the idle state.
// The shared multiplier in the pulse unit (two passes per pulse) and the single angle
// read/write port set the pace of a run. Commands are stalled while a run is in progress.
// Sync reset: angles 0, trims 127, no transaction open, config back to its defaults.

module servo_pulse_commit_with_collision_clamp import spc_pkg::*; #(
  parameter int LEGS        = LEGS_DEF,
  parameter int GRIP_SERVOS = GRIP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  op,
  input  logic [3:0]  servo,
  input  logic [7:0]  angle,
  input  logic [7:0]  trim_value,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [3:0]  channel,
  output logic [11:0] pulse,
  output logic        last
);

  localparam int NSERVO = 2 * LEGS + GRIP_SERVOS;
  localparam int CW     = $clog2(NSERVO);
  localparam int HW     = $clog2(LEGS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD_A  = 7'b0000010,
    S_RD_B  = 7'b0000100,
    S_WR_A  = 7'b0001000,
    S_WR_B  = 7'b0010000,
    S_PULSE = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t        state;
  cfg_t          cfg;
  logic [7:0]    angles [NSERVO];
  logic [7:0]    trims  [NTRIM];
  logic          deferred;
  logic [HW-1:0] hip;
  logic [CW-1:0] cur;
  logic          single;
  logic [7:0]    a_r;
  logic [7:0]    b_r;

  logic          cmd_acc;
  logic          take;
  logic [HW-1:0] hip_nxt;
  logic [CW-1:0] rd_idx;
  logic [7:0]    rd_angle;
  logic [3:0]    trim_idx;
  logic [7:0]    diff;
  logic [7:0]    adj;
  logic [7:0]    a_plus;
  logic [7:0]    b_minus;
  logic          clamp_hit;
  logic          wr_en;
  logic [CW-1:0] wr_idx;
  logic [7:0]    wr_data;
  logic [7:0]    angle_sat;
  logic          cur_last;
  pulse_req_t    pu_req;
  pulse_rsp_t    pu_rsp;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && (state == S_IDLE);
  assign take      = !res_valid || !res_stall;

  always_comb begin
    hip_nxt = (hip == HW'(LEGS - 1)) ? '0 : hip + 1'b1;
    case (state)
      S_RD_A:  rd_idx = CW'(hip);
      S_RD_B:  rd_idx = CW'(hip_nxt);
      default: rd_idx = cur;
    endcase
    rd_angle = angles[rd_idx];
    trim_idx = 4'(cur);

    diff      = b_r - a_r;
    clamp_hit = (a_r <= CLAMP_LO) && (b_r >= CLAMP_HI) && (diff > CLAMP_LO);
    adj       = ((diff - CLAMP_LO) >> 1) + 8'd1;
    a_plus    = a_r + adj;
    b_minus   = b_r - adj;

    angle_sat = (angle > 8'(ANGLE_MAX)) ? 8'(ANGLE_MAX) : angle;
    cur_last  = single || (cur == CW'(NSERVO - 1));

    wr_en   = 1'b0;
    wr_idx  = CW'(servo);
    wr_data = angle_sat;
    case (state)
      S_IDLE: wr_en = cmd_acc && (op_t'(op) == OP_SET) && (servo < NSERVO);
      S_WR_A: begin
        wr_en   = clamp_hit;
        wr_idx  = CW'(hip);
        wr_data = a_plus;
      end
      S_WR_B: begin
        wr_en   = clamp_hit;
        wr_idx  = CW'(hip_nxt);
        wr_data = b_minus;
      end
      default: wr_en = 1'b0;
    endcase

    pu_req.start    = (state == S_PULSE);
    pu_req.angle    = rd_angle;
    pu_req.use_trim = cfg.trim_enable && (int'(cur) < NTRIM);
    pu_req.trim     = (int'(cur) < NTRIM) ? trims[trim_idx] : TRIM_MID_RST;
  end

  spc_pulse_unit u_pulse (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .req  (pu_req),
    .take (take),
    .rsp  (pu_rsp)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trim_enable <= TRIM_EN_RST;
      cfg.pulse_min   <= PULSE_MIN_RST;
      cfg.pulse_max   <= PULSE_MAX_RST;
      cfg.trim_mid    <= TRIM_MID_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TRIM_EN:   cfg.trim_enable <= cfg_data[0];
        CFG_PULSE_MIN: cfg.pulse_min   <= cfg_data;
        CFG_PULSE_MAX: cfg.pulse_max   <= cfg_data;
        CFG_TRIM_MID:  cfg.trim_mid    <= cfg_data[7:0];
        default:       cfg.trim_enable <= cfg.trim_enable;
      endcase
    end
  end

  // angle and trim stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSERVO; i++) angles[i] <= 8'd0;
      for (int i = 0; i < NTRIM; i++) trims[i] <= TRIM_MID_RST;
    end else begin
      if (wr_en) angles[wr_idx] <= wr_data;
      if (cmd_acc && op_t'(op) == OP_TRIM && servo < NTRIM && servo < NSERVO) begin
        trims[servo] <= trim_value;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      deferred <= 1'b0;
      hip      <= '0;
      cur      <= '0;
      single   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (cmd_acc) begin
          case (op_t'(op))
            OP_SET: if (servo < NSERVO && !deferred) begin
              cur    <= CW'(servo);
              single <= 1'b1;
              state  <= S_PULSE;
            end
            OP_BEGIN:  deferred <= 1'b1;
            OP_COMMIT: begin
              deferred <= 1'b0;
              hip      <= '0;
              state    <= S_RD_A;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: state <= S_WR_A;
        S_WR_A: state <= S_WR_B;
        S_WR_B: begin
          if (hip == HW'(LEGS - 1)) begin
            cur    <= '0;
            single <= 1'b0;
            state  <= S_PULSE;
          end else begin
            hip   <= hip_nxt;
            state <= S_RD_A;
          end
        end
        S_PULSE: state <= S_WAIT;
        S_WAIT: if (pu_rsp.done && take) begin
          if (cur_last) begin
            state <= S_IDLE;
          end else begin
            cur   <= cur + 1'b1;
            state <= S_PULSE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD_A) a_r <= rd_angle;
    if (state == S_RD_B) b_r <= rd_angle;
  end

  // output register: the sequencer may go idle while the last beat waits
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_WAIT && pu_rsp.done && take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WAIT && pu_rsp.done && take) begin
      channel <= 4'(cur);
      pulse   <= pu_rsp.value;
      last    <= cur_last;
    end
  end

  a_commit_starts_clamp: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && op_t'(op) == OP_COMMIT |=> state == S_RD_A && hip == '0)
    else $error("commit did not start the hip clamp");

  a_angle_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PULSE || state == S_RD_A || state == S_RD_B |-> rd_angle <= 8'(ANGLE_MAX))
    else $error("stored angle above range");

  a_clamp_order: assert property (@(posedge clk) disable iff (rst)
    state == S_WR_A && clamp_hit |-> a_plus <= b_minus)
    else $error("clamp crossed the pair");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    pu_rsp.done |-> state == S_WAIT)
    else $error("pulse result with no run waiting");

endmodule

@@ hdl/spc_pulse_unit.sv @@
`timescale 1ns / 1ps

module spc_pulse_unit import spc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  pulse_req_t req,
  input  logic       take,
  output pulse_rsp_t rsp
);

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_MUL1 = 4'b0010,
    P_MUL2 = 4'b0100,
    P_SUM  = 4'b1000
  } pstate_t;

  pstate_t            pstate;
  logic [7:0]         angle_r;
  logic [7:0]         trim_r;
  logic               use_trim_r;
  logic               neg;
  logic signed [39:0] prod;

  logic signed [12:0] span;
  logic signed [20:0] prod_lo;
  logic signed [20:0] mag;
  logic signed [19:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [39:0] product;
  logic [12:0]        quo;
  logic signed [14:0] squo;
  logic signed [14:0] trim_d;
  logic signed [14:0] sum;

  always_comb begin
    span    = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
    prod_lo = prod[20:0];
    mag     = prod_lo[20] ? -prod_lo : prod_lo;
    // one multiplier: angle*span first, then the reciprocal of 180
    if (pstate == P_MUL1) begin
      mul_a = $signed({12'd0, angle_r});
      mul_b = $signed({{7{span[12]}}, span});
    end else begin
      mul_a = $signed({2'b00, mag[19:2]});
      mul_b = $signed({1'b0, RECIP_M});
    end
    product = mul_a * mul_b;

    quo    = prod[RECIP_SHIFT +: 13];
    squo   = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    trim_d = use_trim_r ? ($signed({7'd0, trim_r}) - $signed({7'd0, cfg.trim_mid}))
                        : 15'sd0;
    sum    = $signed({3'd0, cfg.pulse_min}) + squo + trim_d;

    rsp.done = (pstate == P_SUM);
    if (sum < 0) begin
      rsp.value = 12'd0;
    end else if (sum > 15'sd4095) begin
      rsp.value = 12'hFFF;
    end else begin
      rsp.value = sum[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= P_IDLE;
    end else begin
      case (pstate)
        P_IDLE: if (req.start) pstate <= P_MUL1;
        P_MUL1: pstate <= P_MUL2;
        P_MUL2: pstate <= P_SUM;
        P_SUM:  if (take) pstate <= P_IDLE;
        default: pstate <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pstate == P_IDLE && req.start) begin
      angle_r    <= req.angle;
      trim_r     <= req.trim;
      use_trim_r <= req.use_trim;
    end
    if (pstate == P_MUL1) begin
      prod <= product;
    end
    if (pstate == P_MUL2) begin
      neg  <= prod[39];
      prod <= product;
    end
  end

endmodule
